FILE: sv/afk_pkg.sv
`timescale 1ns / 1ps
// afk_pkg: shared types and constants of the arm forward kinematics block
// no dependencies

package afk_pkg;

  // q.30 angle and trig formats
  localparam int ANG_W  = 34;
  localparam int TRIG_W = 32;
  localparam int MAX_STEPS = 24;

  typedef logic signed [ANG_W-1:0]  ang_t;
  typedef logic signed [TRIG_W-1:0] trig_t;

  localparam ang_t Q30_PI      = 34'sd3373259426;
  localparam ang_t Q30_HALF_PI = 34'sd1686629713;
  localparam ang_t Q30_TWO_PI  = 34'sd6746518852;
  localparam ang_t CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-i, truncated q.30
  localparam logic [31:0] ATAN_Q30 [MAX_STEPS] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127
  };

  // link register layout
  localparam int LINK_W = 60;
  localparam int COMP_W = 20;
  localparam int ACC_W  = 24;

  typedef logic [LINK_W-1:0] link_t;

  typedef enum logic [1:0] {
    REG_LINK_ONE   = 2'd0,
    REG_LINK_TWO   = 2'd1,
    REG_LINK_THREE = 2'd2,
    REG_LINK_FOUR  = 2'd3
  } reg_idx_t;

endpackage

FILE: sv/afk_cordic.sv
`timescale 1ns / 1ps
// afk_cordic: pipelined rotation-mode cordic with range reduction, one step per stage
// depends on afk_pkg

module afk_cordic import afk_pkg::*; #(
  parameter int ITER = 16
) (
  input  logic clk,
  input  logic en,
  input  ang_t angle_in,
  output trig_t cos_o,
  output trig_t sin_o
);

  ang_t x_r [ITER+1];
  ang_t y_r [ITER+1];
  ang_t a_r [ITER+1];
  logic neg_r [ITER+1];
  trig_t cos_r, sin_r;

  ang_t a_wrap, a_fold;
  logic fold;

  // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    if (angle_in > Q30_PI) begin
      a_wrap = angle_in - Q30_TWO_PI;
    end else if (angle_in < -Q30_PI) begin
      a_wrap = angle_in + Q30_TWO_PI;
    end else begin
      a_wrap = angle_in;
    end
    fold = 1'b1;
    if (a_wrap > Q30_HALF_PI) begin
      a_fold = a_wrap - Q30_PI;
    end else if (a_wrap < -Q30_HALF_PI) begin
      a_fold = a_wrap + Q30_PI;
    end else begin
      a_fold = a_wrap;
      fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]   <= a_fold;
      x_r[0]   <= CORDIC_GAIN;
      y_r[0]   <= '0;
      neg_r[0] <= fold;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < ITER; i++) begin : g_step
    localparam ang_t AT = ang_t'({2'b00, ATAN_Q30[i]});
    ang_t x_nxt, y_nxt, a_nxt;
    always_comb begin
      if (!a_r[i][ANG_W-1]) begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        a_nxt = a_r[i] - AT;
      end else begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        a_nxt = a_r[i] + AT;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]   <= x_nxt;
        y_r[i+1]   <= y_nxt;
        a_r[i+1]   <= a_nxt;
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // undo the fold by negation
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[ITER] ? trig_t'(-x_r[ITER]) : trig_t'(x_r[ITER]);
      sin_r <= neg_r[ITER] ? trig_t'(-y_r[ITER]) : trig_t'(y_r[ITER]);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: sv/afk_rotate.sv
`timescale 1ns / 1ps
// afk_rotate: link rotations, vector sum, base rotation and quaternion rounding
// depends on afk_pkg

module afk_rotate import afk_pkg::*; (
  input  logic clk,
  input  logic en,
  input  trig_t c2, s2, c3, s3, cb, sb, cq, sq,
  input  link_t link_one, link_two, link_three, link_four,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic signed [23:0] pos_z,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_z
);

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [TRIG_W+COMP_W-1:0] lprod_t;
  typedef logic signed [TRIG_W+ACC_W-1:0]  bprod_t;

  comp_t l1x, l1y, l1z, l2x, l2y, l2z, l3x, l3y, l3z, l4x, l4y, l4z;
  assign l1x = link_one[19:0];   assign l1y = link_one[39:20];   assign l1z = link_one[59:40];
  assign l2x = link_two[19:0];   assign l2y = link_two[39:20];   assign l2z = link_two[59:40];
  assign l3x = link_three[19:0]; assign l3y = link_three[39:20]; assign l3z = link_three[59:40];
  assign l4x = link_four[19:0];  assign l4y = link_four[39:20];  assign l4z = link_four[59:40];

  // stage 1: link products
  lprod_t p2cx_r, p2sz_r, p2cz_r, p2sx_r, p3cx_r, p3sz_r, p3cz_r, p3sx_r;
  trig_t cb1_r, sb1_r, cq1_r, sq1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p2cx_r <= c2 * l2x; p2sz_r <= s2 * l2z; p2cz_r <= c2 * l2z; p2sx_r <= s2 * l2x;
      p3cx_r <= c3 * l3x; p3sz_r <= s3 * l3z; p3cz_r <= c3 * l3z; p3sx_r <= s3 * l3x;
      cb1_r <= cb; sb1_r <= sb; cq1_r <= cq; sq1_r <= sq;
    end
  end

  // stage 2: round the rotated links and sum all four
  localparam int LS_W = TRIG_W + COMP_W + 1;
  logic signed [LS_W-1:0] s2x, s2z, s3x, s3z;
  acc_t r2x, r2z, r3x, r3z;
  acc_t acc0_r, acc1_r, acc2_r;
  trig_t cb2_r, sb2_r, cq2_r, sq2_r;
  always_comb begin
    s2x = LS_W'(p2cx_r) + LS_W'(p2sz_r) + (LS_W'(1) <<< 29);
    s2z = LS_W'(p2cz_r) - LS_W'(p2sx_r) + (LS_W'(1) <<< 29);
    s3x = LS_W'(p3cx_r) + LS_W'(p3sz_r) + (LS_W'(1) <<< 29);
    s3z = LS_W'(p3cz_r) - LS_W'(p3sx_r) + (LS_W'(1) <<< 29);
    r2x = acc_t'(s2x >>> 30);
    r2z = acc_t'(s2z >>> 30);
    r3x = acc_t'(s3x >>> 30);
    r3z = acc_t'(s3z >>> 30);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      acc0_r <= acc_t'(l1x) + r2x + r3x + acc_t'(l4x);
      acc1_r <= acc_t'(l1y) + acc_t'(l2y) + acc_t'(l3y) + acc_t'(l4y);
      acc2_r <= acc_t'(l1z) + r2z + r3z + acc_t'(l4z);
      cb2_r <= cb1_r; sb2_r <= sb1_r; cq2_r <= cq1_r; sq2_r <= sq1_r;
    end
  end

  // stage 3: base rotation products
  bprod_t pbcx_r, pbsy_r, pbsx_r, pbcy_r;
  acc_t acc2d_r;
  trig_t cq3_r, sq3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pbcx_r <= cb2_r * acc0_r; pbsy_r <= sb2_r * acc1_r;
      pbsx_r <= sb2_r * acc0_r; pbcy_r <= cb2_r * acc1_r;
      acc2d_r <= acc2_r;
      cq3_r <= cq2_r; sq3_r <= sq2_r;
    end
  end

  // stage 4: round, saturate, output word
  localparam int BS_W = TRIG_W + ACC_W + 1;
  localparam int BR_W = BS_W - 30;
  localparam int QR_W = TRIG_W - 15;
  logic signed [BS_W-1:0] sx, sy;
  logic signed [BR_W-1:0] rx, ry;
  logic signed [QR_W-1:0] rw, rz;

  function automatic logic signed [23:0] sat24(input logic signed [BR_W-1:0] v);
    if (v > BR_W'(8388607)) begin
      return 24'sh7fffff;
    end else if (v < -BR_W'(8388608)) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  function automatic logic signed [15:0] satq(input logic signed [QR_W-1:0] v);
    if (v > QR_W'(16384)) begin
      return 16'sd16384;
    end else if (v < -QR_W'(16384)) begin
      return -16'sd16384;
    end else begin
      return v[15:0];
    end
  endfunction

  always_comb begin
    sx = BS_W'(pbcx_r) - BS_W'(pbsy_r) + (BS_W'(1) <<< 29);
    sy = BS_W'(pbsx_r) + BS_W'(pbcy_r) + (BS_W'(1) <<< 29);
    rx = BR_W'(sx >>> 30);
    ry = BR_W'(sy >>> 30);
    rw = QR_W'((TRIG_W'(cq3_r) + TRIG_W'(32768)) >>> 15) >>> 1;
    rz = QR_W'((TRIG_W'(sq3_r) + TRIG_W'(32768)) >>> 15) >>> 1;
  end

  logic signed [23:0] px_r, py_r, pz_r;
  logic signed [15:0] qw_r, qz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= sat24(rx);
      py_r <= sat24(ry);
      pz_r <= sat24(BR_W'(acc2d_r));
      qw_r <= satq(rw);
      qz_r <= satq(rz);
    end
  end

  assign pos_x  = px_r;
  assign pos_y  = py_r;
  assign pos_z  = pz_r;
  assign quat_w = qw_r;
  assign quat_z = qz_r;

endmodule

FILE: sv/arm_forward_kinematics.sv
`timescale 1ns / 1ps
// throughput: one word per cycle; the cordic step chain and the rotation stages all advance
// together and hold as a whole only while the output word waits
// reset: synchronous active low rst_n clears the valid bits and the link registers to zero
// depends on afk_pkg, afk_cordic, afk_rotate

module arm_forward_kinematics import afk_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_base_angle,
  input  logic signed [15:0] in_shoulder_angle,
  input  logic signed [15:0] in_elbow_angle,
  input  logic signed [15:0] in_wrist_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_quat_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [LINK_W-1:0]  cfg_data
);

  // cordic steps, capped at the arctangent table length
  localparam int STEPS = (TRIG_ITERATIONS > MAX_STEPS) ? MAX_STEPS : TRIG_ITERATIONS;
  localparam int LAT = STEPS + 6;

  logic en;
  logic [LAT-1:0] vld_r;

  // whole pipeline moves unless the output word is stalled
  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // link registers
  link_t link_one_r, link_two_r, link_three_r, link_four_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_one_r   <= '0;
      link_two_r   <= '0;
      link_three_r <= '0;
      link_four_r  <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINK_ONE:   link_one_r   <= cfg_data;
        REG_LINK_TWO:   link_two_r   <= cfg_data;
        REG_LINK_THREE: link_three_r <= cfg_data;
        REG_LINK_FOUR:  link_four_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // q3.12 to q.30 angles; half yaw from the 17-bit sum
  ang_t a_sh, a_el, a_bs, a_hy;
  logic signed [16:0] yaw_sum;
  assign yaw_sum = 17'(in_base_angle) + 17'(in_wrist_angle);
  assign a_sh = {in_shoulder_angle, 18'b0};
  assign a_el = {in_elbow_angle, 18'b0};
  assign a_bs = {in_base_angle, 18'b0};
  assign a_hy = {yaw_sum, 17'b0};

  trig_t c2, s2, c3, s3, cb, sb, cq, sq;

  afk_cordic #(.ITER(STEPS)) u_cordic_sh (
    .clk(clk), .en(en), .angle_in(a_sh), .cos_o(c2), .sin_o(s2));
  afk_cordic #(.ITER(STEPS)) u_cordic_el (
    .clk(clk), .en(en), .angle_in(a_el), .cos_o(c3), .sin_o(s3));
  afk_cordic #(.ITER(STEPS)) u_cordic_bs (
    .clk(clk), .en(en), .angle_in(a_bs), .cos_o(cb), .sin_o(sb));
  afk_cordic #(.ITER(STEPS)) u_cordic_hy (
    .clk(clk), .en(en), .angle_in(a_hy), .cos_o(cq), .sin_o(sq));

  afk_rotate u_rotate (
    .clk(clk), .en(en),
    .c2(c2), .s2(s2), .c3(c3), .s3(s3), .cb(cb), .sb(sb), .cq(cq), .sq(sq),
    .link_one(link_one_r), .link_two(link_two_r),
    .link_three(link_three_r), .link_four(link_four_r),
    .pos_x(out_pos_x), .pos_y(out_pos_y), .pos_z(out_pos_z),
    .quat_w(out_quat_w), .quat_z(out_quat_z)
  );

endmodule

FILE: bench/afk_checker.sv
`timescale 1ns / 1ps
// afk_checker: watches the joint, pose and link register channels of arm_forward_kinematics
// and predicts each pose word and compares it; depends on afk_pkg

module afk_checker import afk_pkg::*; #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_base_angle,
  input  logic signed [15:0] in_shoulder_angle,
  input  logic signed [15:0] in_elbow_angle,
  input  logic signed [15:0] in_wrist_angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [23:0] out_pos_x,
  input  logic signed [23:0] out_pos_y,
  input  logic signed [23:0] out_pos_z,
  input  logic signed [15:0] out_quat_w,
  input  logic signed [15:0] out_quat_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [LINK_W-1:0]  cfg_data,
  output int                 fail_count,
  output int                 poses_pending,
  output int                 poses_checked
);

  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic signed [15:0] qw;
    logic signed [15:0] qz;
  } pose_t;

  pose_t pose_q[$];
  link_t links[4];

  // one link component, sign extended
  function automatic longint link_comp(input link_t r, input int k);
    logic signed [COMP_W-1:0] f;
    f = r[k*COMP_W +: COMP_W];
    return longint'(f);
  endfunction

  function automatic longint round_q30(input longint p);
    return (p + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // range-reduced rotation-mode cordic, q.30 in and out
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint a, x, y, nx, pi, hpi, tpi;
    bit flip;
    int steps;
    pi = longint'(Q30_PI);
    hpi = longint'(Q30_HALF_PI);
    tpi = longint'(Q30_TWO_PI);
    a = ang;
    flip = 0;
    x = longint'(CORDIC_GAIN);
    y = 0;
    steps = TRIG_ITERATIONS > MAX_STEPS ? MAX_STEPS : TRIG_ITERATIONS;
    if (a > pi) a -= tpi;
    else if (a < -pi) a += tpi;
    if (a > hpi) begin
      a -= pi;
      flip = 1;
    end else if (a < -hpi) begin
      a += pi;
      flip = 1;
    end
    for (int i = 0; i < steps; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        a -= longint'(ATAN_Q30[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        a += longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic pose_t predict_pose(input longint b, input longint sh,
                                         input longint el, input longint wr);
    pose_t p;
    longint ax, ay, az, c, s, vx, vz;
    ax = link_comp(links[REG_LINK_ONE], 0) + link_comp(links[REG_LINK_FOUR], 0);
    ay = link_comp(links[REG_LINK_ONE], 1) + link_comp(links[REG_LINK_FOUR], 1);
    az = link_comp(links[REG_LINK_ONE], 2) + link_comp(links[REG_LINK_FOUR], 2);
    // upper arm about y by shoulder
    sin_cos(sh * 262144, c, s);
    vx = link_comp(links[REG_LINK_TWO], 0);
    vz = link_comp(links[REG_LINK_TWO], 2);
    ax += round_q30(c * vx + s * vz);
    ay += link_comp(links[REG_LINK_TWO], 1);
    az += round_q30(c * vz - s * vx);
    // forearm about y by elbow
    sin_cos(el * 262144, c, s);
    vx = link_comp(links[REG_LINK_THREE], 0);
    vz = link_comp(links[REG_LINK_THREE], 2);
    ax += round_q30(c * vx + s * vz);
    ay += link_comp(links[REG_LINK_THREE], 1);
    az += round_q30(c * vz - s * vx);
    // whole sum about z by base
    sin_cos(b * 262144, c, s);
    p.px = 24'(clamp(round_q30(c * ax - s * ay), -8388608, 8388607));
    p.py = 24'(clamp(round_q30(s * ax + c * ay), -8388608, 8388607));
    p.pz = 24'(clamp(az, -8388608, 8388607));
    // yaw quaternion from half of base plus wrist
    sin_cos((b + wr) * 131072, c, s);
    p.qw = 16'(clamp((c + 32768) >>> 16, -16384, 16384));
    p.qz = 16'(clamp((s + 32768) >>> 16, -16384, 16384));
    return p;
  endfunction

  assign poses_pending = pose_q.size();

  // track registers, predict on joint words, compare on pose words
  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) links[i] = '0;
      pose_q.delete();
      fail_count <= 0;
      poses_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) links[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        pose_q.push_back(predict_pose(in_base_angle, in_shoulder_angle,
                                      in_elbow_angle, in_wrist_angle));
      if (out_valid && out_ready) begin
        poses_checked <= poses_checked + 1;
        if (pose_q.size() == 0) begin
          $error("pose word with no joint word outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = pose_q.pop_front();
          if (out_pos_x !== e.px || out_pos_y !== e.py || out_pos_z !== e.pz ||
              out_quat_w !== e.qw || out_quat_z !== e.qz) begin
            fail_count <= fail_count + 1;
            if (out_pos_x !== e.px)
              $error("pos_x expected %0d actual %0d", e.px, out_pos_x);
            if (out_pos_y !== e.py)
              $error("pos_y expected %0d actual %0d", e.py, out_pos_y);
            if (out_pos_z !== e.pz)
              $error("pos_z expected %0d actual %0d", e.pz, out_pos_z);
            if (out_quat_w !== e.qw)
              $error("quat_w expected %0d actual %0d", e.qw, out_quat_w);
            if (out_quat_z !== e.qz)
              $error("quat_z expected %0d actual %0d", e.qz, out_quat_z);
          end
        end
      end
    end
  end

endmodule

FILE: bench/tb_arm_forward_kinematics.sv
`timescale 1ns / 1ps
// tb_arm_forward_kinematics: joint word stimulus, link register phases and verdict
// depends on afk_pkg, afk_checker and the arm_forward_kinematics rtl

module tb_arm_forward_kinematics import afk_pkg::*;;

  localparam int ITERS = 16;
  localparam int SETTLE = ITERS + 16;
  localparam int WATCH_LIMIT = 4000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_base_angle;
  logic signed [15:0] in_shoulder_angle;
  logic signed [15:0] in_elbow_angle;
  logic signed [15:0] in_wrist_angle;
  logic               out_valid;
  logic               out_ready;
  logic signed [23:0] out_pos_x;
  logic signed [23:0] out_pos_y;
  logic signed [23:0] out_pos_z;
  logic signed [15:0] out_quat_w;
  logic signed [15:0] out_quat_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [LINK_W-1:0]  cfg_data;

  int fail_count;
  int poses_pending;
  int poses_checked;
  int joints_sent;
  int idle_cycles;
  bit calm;
  bit hold_done;

  arm_forward_kinematics #(.TRIG_ITERATIONS(ITERS)) DUT (.*);

  afk_checker #(.TRIG_ITERATIONS(ITERS)) u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else if (idle_cycles >= WATCH_LIMIT) begin
      $display("timeout with %0d poses outstanding", poses_pending);
      $display("** arm_forward_kinematics: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // pose receiver: random stall bursts, one long hold while joints keep coming
  initial begin
    out_ready <= 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && joints_sent >= 400) begin
        hold_done = 1;
        out_ready <= 0;
        repeat (200) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1;
        @(posedge clk);
      end
    end
  end

  // one register write, after which the write channel goes idle
  task automatic write_link(input reg_idx_t idx, input link_t val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function automatic link_t pack_link(input logic [19:0] x, input logic [19:0] y,
                                      input logic [19:0] z);
    return {z, y, x};
  endfunction

  function automatic link_t rand_link();
    return pack_link(20'($urandom), 20'($urandom), 20'($urandom));
  endfunction

  // let the pipe drain before touching the link registers
  task automatic drain();
    while (poses_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_joints(input logic [15:0] b, input logic [15:0] s,
                             input logic [15:0] e, input logic [15:0] w);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_base_angle <= b;
    in_shoulder_angle <= s;
    in_elbow_angle <= e;
    in_wrist_angle <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    joints_sent++;
  endtask

  // mostly angles within one turn, some anywhere in the field
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 25736)) - 12868);
  endfunction

  task automatic random_joints(input int n);
    repeat (n) send_joints(rand_angle(), rand_angle(), rand_angle(), rand_angle());
    in_valid <= 0;
  endtask

  initial begin
    logic [15:0] edges[10];
    edges = '{16'sd0, 16'sd32767, 16'sh8000, 16'sd12868, -16'sd12868,
              16'sd6434, -16'sd6434, 16'sd6435, -16'sd6435, 16'sd25736};
    rst_n <= 0;
    in_valid <= 0;
    cfg_valid <= 0;
    cfg_index <= REG_LINK_ONE;
    cfg_data <= '0;
    in_base_angle <= 0;
    in_shoulder_angle <= 0;
    in_elbow_angle <= 0;
    in_wrist_angle <= 0;
    joints_sent = 0;
    calm = 0;
    hold_done = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // typical arm lengths, then the angle edges and wrap points
    write_link(REG_LINK_ONE, pack_link(20'd0, 20'd0, 20'd9830));
    write_link(REG_LINK_TWO, pack_link(20'd0, 20'd0, 20'd11141));
    write_link(REG_LINK_THREE, pack_link(20'd9830, 20'd0, 20'd0));
    write_link(REG_LINK_FOUR, pack_link(20'd3932, -20'sd1000, -20'sd4000));
    for (int i = 0; i < 10; i++)
      send_joints(edges[i], edges[(i + 3) % 10], edges[(i + 7) % 10], edges[i]);
    send_joints(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_joints(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_joints(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    send_joints(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    random_joints(500);
    drain();

    // all components at the positive extreme
    for (int r = 0; r < 4; r++)
      write_link(reg_idx_t'(r), pack_link(20'h7FFFF, 20'h7FFFF, 20'h7FFFF));
    random_joints(300);
    drain();

    // all components at the negative extreme
    for (int r = 0; r < 4; r++)
      write_link(reg_idx_t'(r), pack_link(20'h80000, 20'h80000, 20'h80000));
    random_joints(300);
    drain();

    // random link vectors, last stretch without any idling
    for (int r = 0; r < 4; r++) write_link(reg_idx_t'(r), rand_link());
    random_joints(400);
    drain();
    for (int r = 0; r < 4; r++) write_link(reg_idx_t'(r), rand_link());
    calm = 1;
    random_joints(300);
    drain();

    $display("sent %0d joint words over five link settings, checked %0d poses",
             joints_sent, poses_checked);
    if (fail_count == 0 && poses_pending == 0)
      $display("** arm_forward_kinematics: PASSED **");
    else
      $display("** arm_forward_kinematics: FAILED **");
    $finish;
  end

endmodule
